@@ rtl/ssprx_pkg.sv @@
// Shared types and constants of the servo status packet receiver.
`timescale 1ns / 1ps
package ssprx_pkg;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_ID     = 3'd1,
		PH_LEN    = 3'd2,
		PH_STATUS = 3'd3,
		PH_DATA   = 3'd4,
		PH_CSUM   = 3'd5
	} phase_t;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_NOHDR    = 3'd1;
	localparam logic [2:0] ERR_SHORT    = 3'd2;
	localparam logic [2:0] ERR_CHECKSUM = 3'd3;
	localparam logic [2:0] ERR_ID       = 3'd4;
	localparam logic [2:0] ERR_TIMEOUT  = 3'd5;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] ANY_ID       = 8'hFE;
	localparam logic [7:0] LIMIT_RESET  = 8'd20;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	localparam logic [1:0] REG_LIMIT = 2'd0;

	typedef struct packed {
		logic [2:0] error_code;
		logic [7:0] payload_len;
		logic [7:0] status_byte;
		logic [7:0] servo_id;
		logic [7:0] data_byte;
		logic       result_kind;
	} result_t;

endpackage

@@ rtl/servo_status_packet_receiver_unit.sv @@
// Throughput: one input beat per cycle; a stall on the master side holds the input register.
// An input register feeds the per-byte parser, whose result lands in the output register.
// Reset (arst_n low, asynchronous): parser hunts for the header, search limit 20,
// expected id 0xFE, captured fields and checksum sum cleared, both stages empty.
`timescale 1ns / 1ps
module servo_status_packet_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], exp_id[15:8]
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // data_byte, servo_id, status_byte, payload_len, error_code
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  expid_s1;
	logic        advance;

	logic [7:0]  limit_q;

	ssprx_pkg::phase_t phase_q, phase_d;
	logic        prev_ff_q, prev_ff_d;
	logic [7:0]  hunt_q, hunt_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  cid_q, cid_d;
	logic [7:0]  clen_q, clen_d;
	logic [7:0]  cstat_q, cstat_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic        has_res;
	logic [2:0]  res_err;

	ssprx_pkg::result_t res;
	ssprx_pkg::result_t out_q;
	logic        out_valid_q;

	logic [7:0]  limit_eff;
	logic [7:0]  hunt_inc;
	logic [7:0]  sum_add;
	logic [7:0]  left_dec;
	logic        reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = ({1'b0, paddr[2]} == ssprx_pkg::REG_LIMIT);
	assign prdata  = reg_hit ? {24'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ssprx_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			limit_q <= pwdata[7:0];
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser;
			byte_s1  <= s_axis_tdata[7:0];
			expid_s1 <= s_axis_tdata[15:8];
		end
	end

	assign limit_eff = (limit_q == 8'd0) ? 8'd1 : limit_q;
	assign hunt_inc  = hunt_q + 8'd1;
	assign sum_add   = sum_q + byte_s1;
	assign left_dec  = left_q - 8'd1;

	// next state
	always_comb begin
		phase_d   = phase_q;
		prev_ff_d = prev_ff_q;
		hunt_d    = hunt_q;
		exp_d     = exp_q;
		cid_d     = cid_q;
		clen_d    = clen_q;
		cstat_d   = cstat_q;
		left_d    = left_q;
		sum_d     = sum_q;
		has_res   = 1'b0;
		res_err   = ssprx_pkg::ERR_OK;
		if (op_s1 == ssprx_pkg::OP_TIMEOUT) begin
			has_res   = 1'b1;
			res_err   = ssprx_pkg::ERR_TIMEOUT;
			phase_d   = ssprx_pkg::PH_HUNT;
			prev_ff_d = 1'b0;
			hunt_d    = 8'd0;
		end else begin
			case (phase_q)
				ssprx_pkg::PH_HUNT: begin
					exp_d = expid_s1;
					if (byte_s1 == ssprx_pkg::HDR_BYTE && prev_ff_q) begin
						phase_d   = ssprx_pkg::PH_ID;
						prev_ff_d = 1'b0;
						hunt_d    = 8'd0;
						cid_d     = 8'd0;
						clen_d    = 8'd0;
						cstat_d   = 8'd0;
						left_d    = 8'd0;
						sum_d     = 8'd0;
					end else if (hunt_inc >= limit_eff) begin
						has_res   = 1'b1;
						res_err   = ssprx_pkg::ERR_NOHDR;
						cid_d     = 8'd0;
						clen_d    = 8'd0;
						cstat_d   = 8'd0;
						prev_ff_d = 1'b0;
						hunt_d    = 8'd0;
					end else begin
						prev_ff_d = (byte_s1 == ssprx_pkg::HDR_BYTE);
						hunt_d    = hunt_inc;
					end
				end
				ssprx_pkg::PH_ID: begin
					cid_d   = byte_s1;
					sum_d   = byte_s1;
					phase_d = ssprx_pkg::PH_LEN;
				end
				ssprx_pkg::PH_LEN: begin
					if (byte_s1 < ssprx_pkg::LEN_OVERHEAD) begin
						has_res   = 1'b1;
						res_err   = ssprx_pkg::ERR_SHORT;
						clen_d    = 8'd0;
						phase_d   = ssprx_pkg::PH_HUNT;
						prev_ff_d = 1'b0;
						hunt_d    = 8'd0;
					end else begin
						clen_d  = byte_s1;
						sum_d   = sum_add;
						left_d  = byte_s1 - ssprx_pkg::LEN_OVERHEAD;
						phase_d = ssprx_pkg::PH_STATUS;
					end
				end
				ssprx_pkg::PH_STATUS: begin
					cstat_d = byte_s1;
					sum_d   = sum_add;
					phase_d = (left_q != 8'd0) ? ssprx_pkg::PH_DATA : ssprx_pkg::PH_CSUM;
				end
				ssprx_pkg::PH_DATA: begin
					has_res = 1'b1;
					sum_d   = sum_add;
					left_d  = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = ssprx_pkg::PH_CSUM;
					end
				end
				ssprx_pkg::PH_CSUM: begin
					has_res   = 1'b1;
					phase_d   = ssprx_pkg::PH_HUNT;
					prev_ff_d = 1'b0;
					hunt_d    = 8'd0;
					if (byte_s1 != ~sum_q) begin
						res_err = ssprx_pkg::ERR_CHECKSUM;
					end else if (exp_q != ssprx_pkg::ANY_ID && cid_q != exp_q) begin
						res_err = ssprx_pkg::ERR_ID;
					end else begin
						res_err = ssprx_pkg::ERR_OK;
					end
				end
				default: begin
					phase_d   = ssprx_pkg::PH_HUNT;
					prev_ff_d = 1'b0;
					hunt_d    = 8'd0;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		res.result_kind = (phase_q == ssprx_pkg::PH_DATA && op_s1 == ssprx_pkg::OP_BYTE) ?
			ssprx_pkg::KIND_PAYLOAD : ssprx_pkg::KIND_REPORT;
		res.data_byte   = (res.result_kind == ssprx_pkg::KIND_PAYLOAD) ? byte_s1 : 8'd0;
		res.servo_id    = cid_d;
		res.status_byte = cstat_d;
		res.payload_len = (clen_d >= ssprx_pkg::LEN_OVERHEAD) ?
			clen_d - ssprx_pkg::LEN_OVERHEAD : 8'd0;
		res.error_code  = res_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ssprx_pkg::PH_HUNT;
			prev_ff_q <= 1'b0;
			hunt_q    <= 8'd0;
			exp_q     <= ssprx_pkg::ANY_ID;
			cid_q     <= 8'd0;
			clen_q    <= 8'd0;
			cstat_q   <= 8'd0;
			left_q    <= 8'd0;
			sum_q     <= 8'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			prev_ff_q <= prev_ff_d;
			hunt_q    <= hunt_d;
			exp_q     <= exp_d;
			cid_q     <= cid_d;
			clen_q    <= clen_d;
			cstat_q   <= cstat_d;
			left_q    <= left_d;
			sum_q     <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.result_kind;
	assign m_axis_tdata  = {5'd0, out_q.error_code, out_q.payload_len, out_q.status_byte,
		out_q.servo_id, out_q.data_byte};

endmodule

@@ rtl/ssprx_checker.sv @@
// Port-level checks of the servo status packet receiver, bound to the top level.
`timescale 1ns / 1ps
module ssprx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [2:0] err;

	assign err = m_axis_tdata[34:32];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> err == ssprx_pkg::ERR_OK)
		else $error("payload beat carries an error code");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> err <= ssprx_pkg::ERR_TIMEOUT)
		else $error("error code out of range");

	a_nohdr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && err == ssprx_pkg::ERR_NOHDR |->
			m_axis_tdata[31:0] == 32'd0)
		else $error("no-header report carries captured fields");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && err == ssprx_pkg::ERR_SHORT |->
			m_axis_tdata[31:24] == 8'd0)
		else $error("short-length report carries a payload length");

endmodule

bind servo_status_packet_receiver_unit ssprx_checker u_ssprx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
